FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define CHK_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

FILE: sv/hcs_pkg.sv
// Package for the coverage sweep: operation codes, queue entry type, limits and a saturating add.
// No dependencies.
package hcs_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [29:0] LEN_MAX = 30'h3FFFFFFF;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;
  localparam int IN_BITS  = 105;
  localparam int OUT_BITS = 288;
  // position width, fixed by the 30-bit position fields of a beat
  localparam int POS_BITS = 30;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  region_index;
    logic [29:0] region_start;
    logic [29:0] region_end;
    logic [29:0] event_pos;
    logic        event_haplo;
    logic        event_begin;
    logic        last_event;
  } item_t;

  function automatic logic [29:0] sat_add(input logic [29:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, LEN_MAX}) ? LEN_MAX : s[29:0];
  endfunction
endpackage

FILE: sv/hcs_front.sv
// Front: accepts input beats, unpacks them and pushes them into a short queue.
// Depends on hcs_pkg.
module hcs_front import hcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_BITS-1:0] s_tdata,
  input  logic               pop,
  output logic               q_valid,
  output item_t              q_item
);
  localparam int QD = 4;
  item_t q [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  item_t in_item;
  logic push;

  always_comb begin
    in_item.operation    = s_tdata[1:0];
    in_item.region_index = s_tdata[11:2];
    in_item.region_start = s_tdata[41:12];
    in_item.region_end   = s_tdata[71:42];
    in_item.event_pos    = s_tdata[101:72];
    in_item.event_haplo  = s_tdata[102];
    in_item.event_begin  = s_tdata[103];
    in_item.last_event   = s_tdata[104];
  end

  assign s_tready = (cnt != 3'(QD));
  assign push = s_tvalid && s_tready;
  assign q_valid = (cnt != 3'd0);
  assign q_item = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= in_item;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop && q_valid) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop && q_valid);
    end
  end
endmodule

FILE: sv/hcs_back.sv
// Back: region table memory, scan sequencer, depth and total accumulation.
// Depends on hcs_pkg.
module hcs_back import hcs_pkg::*; #(
  parameter int REGION_ENTRIES = 1024,
  parameter int DEPTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                target_haplo,
  input  logic [10:0]         region_count,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata
);
  localparam int AW = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int CW = $clog2(REGION_ENTRIES + 1) + 1;
  localparam logic [DEPTH_BITS-1:0] DMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_CHECK = 4'b0100, S_ACC = 4'b1000
  } state_t;
  state_t state;

  logic [2*POS_BITS-1:0] mem [REGION_ENTRIES];
  logic [2*POS_BITS-1:0] rd;
  logic [CW-1:0] idx, lim;
  item_t cur;
  logic [POS_BITS-1:0] lo, hi, prev, pos;
  logic [POS_BITS:0] uval;
  logic [DEPTH_BITS-1:0] d0, d1;
  logic seen;
  logic [29:0] tot [8];
  logic [23:0] gc0, gc1;

  logic [POS_BITS-1:0] ra, rb, top, bot;
  logic hit;
  assign pos = cur.event_pos[POS_BITS-1:0];
  assign ra = rd[POS_BITS-1:0];
  assign rb = rd[2*POS_BITS-1:POS_BITS];
  assign hit = (lo < rb) && (hi > ra);
  assign top = (hi < rb) ? hi : rb;
  assign bot = (ra > lo) ? ra : lo;

  logic [POS_BITS:0] span, cval;
  logic [DEPTH_BITS-1:0] dtg;
  assign span = {1'b0, hi} - {1'b0, lo};
  assign cval = span - uval;
  assign dtg = target_haplo ? d1 : d0;

  assign pop = (state == S_IDLE) && q_valid && !m_tvalid;

  always_ff @(posedge clk) begin
    if (pop && q_item.operation == OP_LOAD &&
        {22'b0, q_item.region_index} < 32'(REGION_ENTRIES))
      mem[AW'(q_item.region_index)] <=
        {q_item.region_end[POS_BITS-1:0], q_item.region_start[POS_BITS-1:0]};
    rd <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; d0 <= '0; d1 <= '0; seen <= 1'b0;
      prev <= '0; gc0 <= '0; gc1 <= '0; idx <= '0;
      for (int k = 0; k < 8; k++) tot[k] <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (pop) begin
          cur <= q_item;
          case (q_item.operation)
            OP_CLEAR: begin
              d0 <= '0; d1 <= '0; seen <= 1'b0; prev <= '0; gc0 <= '0; gc1 <= '0;
              for (int k = 0; k < 8; k++) tot[k] <= '0;
            end
            OP_EVENT: begin
              lo <= prev; hi <= q_item.event_pos[POS_BITS-1:0];
              uval <= '0; idx <= '0;
              lim <= (32'(region_count) > 32'(REGION_ENTRIES)) ?
                     CW'(REGION_ENTRIES) : CW'(region_count);
              state <= S_READ;
            end
            default: ;
          endcase
        end
        S_READ: state <= (idx < lim && seen && hi > lo) ? S_CHECK : S_ACC;
        S_CHECK: begin
          if (hit) begin
            uval <= (top > bot) ? {1'b0, top - bot} : '0;
            state <= S_ACC;
          end else begin
            idx <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_ACC: begin
          if (!seen) begin
            seen <= 1'b1; prev <= pos;
            if (cur.event_haplo) begin if (d1 != DMAX) d1 <= d1 + 1'b1; end
            else if (d0 != DMAX) d0 <= d0 + 1'b1;
          end else begin
            if (hi > lo) begin
              prev <= pos;
              if (d0 == 0 && d1 == 0) begin
                if (uval != 0) begin
                  tot[7] <= sat_add(tot[7], 31'(uval));
                  if (gc1 != CNT_MAX) gc1 <= gc1 + 24'd1;
                end else begin
                  tot[6] <= sat_add(tot[6], 31'(cval));
                  if (gc0 != CNT_MAX) gc0 <= gc0 + 24'd1;
                end
              end else tot[0] <= sat_add(tot[0], 31'(cval));
              if (d0 != 0 && d1 != 0) begin
                tot[1] <= sat_add(tot[1], 31'(cval));
                if (d0 > 1 || d1 > 1) tot[2] <= sat_add(tot[2], 31'(cval));
                if (d0 > 1 && d1 > 1) tot[3] <= sat_add(tot[3], 31'(cval));
              end
              if (dtg != 0) tot[4] <= sat_add(tot[4], 31'(uval));
              if (dtg > 1) tot[5] <= sat_add(tot[5], 31'(uval));
            end
            if (cur.event_haplo) begin
              if (cur.event_begin) begin if (d1 != DMAX) d1 <= d1 + 1'b1; end
              else if (d1 != 0) d1 <= d1 - 1'b1;
            end else begin
              if (cur.event_begin) begin if (d0 != DMAX) d0 <= d0 + 1'b1; end
              else if (d0 != 0) d0 <= d0 - 1'b1;
            end
          end
          if (cur.last_event) m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // totals are final when valid rises; later items wait for the beat to drain
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 8; k++) m_tdata[k*30 +: 30] = tot[k];
    m_tdata[263:240] = gc0;
    m_tdata[287:264] = gc1;
  end
endmodule

FILE: sv/haplotype_coverage_sweep.sv
// Coverage sweep over sorted read begin/end events with a unique region table.
// Slave channel s_*: one beat per item; fields in s_tdata (see port comment).
// Master channel m_*: one beat of ten totals after an event with last_event set.
// Config: cfg_we/cfg_index/cfg_data, 0 target_haplo, 1 region_count.
// Items are written into a 4-entry queue and popped from it by the back end when idle.
// Clear and load are handled when popped; an event runs READ and CHECK over
// the table entries in turn (up to region_count, at most REGION_ENTRIES)
// until one intersects the span or none are left, then ACC; the single-port
// table is read once per entry checked.
// The result beat stays until m_tready; the back end holds further items
// while it waits, and the queue keeps taking beats until full.
// Reset clears depths, totals and counts; the table is undefined until
// loaded, the queue empties and the config registers return to zero.
module haplotype_coverage_sweep import hcs_pkg::*; #(
  parameter int REGION_ENTRIES = 1024,
  parameter int DEPTH_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation, region_index, region_start, region_end, event_pos,
  // event_haplo, event_begin, last_event; zero padded
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // covered_any, covered_both, covered_two_one, covered_two_two, unique_onex,
  // unique_twox, common_gap_len, unique_gap_len, common_gap_count, unique_gap_count
  output logic [287:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [10:0]  cfg_data
);
  logic target_haplo;
  logic [10:0] region_count;
  logic q_valid, pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_haplo <= 1'b0; region_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TARGET) target_haplo <= cfg_data[0];
      else region_count <= cfg_data;
    end
  end

  hcs_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata(s_tdata[IN_BITS-1:0]),
    .pop, .q_valid, .q_item
  );

  hcs_back #(.REGION_ENTRIES(REGION_ENTRIES), .DEPTH_BITS(DEPTH_BITS)) u_back (
    .clk, .rst, .target_haplo, .region_count, .q_valid, .q_item, .pop,
    .m_tvalid, .m_tready, .m_tdata
  );
endmodule

FILE: sv/hcs_checker.sv
// Port-level checks for the coverage sweep, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module hcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [287:0] m_tdata
);
  `CHK_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `CHK_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `CHK_NEXT(a_one_result, clk, rst, m_tvalid && m_tready, !m_tvalid)
  `CHK_IMPL(a_data_known, clk, rst, m_tvalid, !$isunknown(m_tdata))
endmodule

bind haplotype_coverage_sweep hcs_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
